[rtl/sgmpa_pkg.sv]
// Shared types, constants and helper functions for the SGM path cost aggregation block.
// No dependencies; imported by every module of the block.
package sgmpa_pkg;

  localparam int COST_W     = 16;
  localparam int PEN_W      = 16;
  localparam int COLOR_W    = 8;
  localparam int GRAD_W     = 8;
  localparam int THR_W      = 9;
  localparam int COUNT_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEFAULT_MAX_DISPARITIES = 128;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISPARITY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_PENALTY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_PENALTY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_THRESHOLD = 2'd3;

  // configuration reset values
  localparam logic [COUNT_W-1:0] COUNT_RESET = 8'd64;
  localparam logic [PEN_W-1:0]   P1_RESET    = 16'd256;
  localparam logic [PEN_W-1:0]   P2_RESET    = 16'd768;
  localparam logic [THR_W-1:0]   THR_RESET   = 9'd20;

  // penalty reduction: quarter is a shift by two, tenth is a reciprocal multiply
  localparam int                QUARTER_SHIFT = 2;
  localparam logic [PEN_W-1:0]  TENTH_RECIP   = 16'hCCCD;
  localparam int                TENTH_SHIFT   = 19;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic valid;
    logic first;   // element of a path start pixel
    logic last;    // final disparity of the pixel
    logic d_zero;  // disparity zero of the pixel
  } item_ctl_t;

  typedef struct packed {
    logic  d_zero;
    rgb_t  cur_left;
    rgb_t  prev_left;
    rgb_t  right;
    rgb_t  right_prev;
    logic  right_valid;
  } grad_in_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [PEN_W-1:0] p1;
    logic [PEN_W-1:0] p2;
    logic [PEN_W-1:0] p1_tenth;
    logic [PEN_W-1:0] p2_tenth;
  } pen_cfg_t;

  typedef struct packed {
    logic [PEN_W-1:0] p1;
    logic [PEN_W-1:0] p2;
  } penalty_t;

  typedef struct packed {
    item_ctl_t         ctl;
    logic [COST_W-1:0] match_cost;
    logic [PEN_W-1:0]  p1;
    logic [PEN_W-1:0]  p2;
    logic [COST_W-1:0] old_cost;
    logic [COST_W-1:0] next_cost;
  } cost_in_t;

  // largest per-channel absolute difference
  function automatic logic [GRAD_W-1:0] color_grad(input rgb_t a, input rgb_t b);
    logic [COLOR_W-1:0] dr;
    logic [COLOR_W-1:0] dg;
    logic [COLOR_W-1:0] db;
    logic [COLOR_W-1:0] m;
    dr = (a.red   >= b.red)   ? (a.red   - b.red)   : (b.red   - a.red);
    dg = (a.green >= b.green) ? (a.green - b.green) : (b.green - a.green);
    db = (a.blue  >= b.blue)  ? (a.blue  - b.blue)  : (b.blue  - a.blue);
    m = dr;
    if (dg > m) m = dg;
    if (db > m) m = db;
    return GRAD_W'(m);
  endfunction

  // floor(x / 10), exact for 16-bit x
  function automatic logic [PEN_W-1:0] div_ten(input logic [PEN_W-1:0] x);
    logic [2*PEN_W-1:0] prod;
    prod = (2*PEN_W)'(x) * (2*PEN_W)'(TENTH_RECIP);
    return PEN_W'(prod >> TENTH_SHIFT);
  endfunction

endpackage

[rtl/sgmpa_penalty.sv]
// Color gradient and penalty selection for one disparity element.
// Holds the last valid right gradient of the pixel. Depends on sgmpa_pkg.
module sgmpa_penalty import sgmpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  grad_in_t gin,
  input  pen_cfg_t cfg,
  output penalty_t pen
);

  logic [GRAD_W-1:0] held_grad;
  logic [GRAD_W-1:0] grad_left;
  logic [GRAD_W-1:0] grad_right;
  logic              left_low;
  logic              right_low;

  always_comb begin
    grad_left = color_grad(gin.cur_left, gin.prev_left);
    if (gin.right_valid) begin
      grad_right = color_grad(gin.right, gin.right_prev);
    end else if (gin.d_zero) begin
      grad_right = grad_left;   // right gradient starts each pixel at the left one
    end else begin
      grad_right = held_grad;
    end
    left_low  = THR_W'(grad_left)  < cfg.threshold;
    right_low = THR_W'(grad_right) < cfg.threshold;
    case ({left_low, right_low})
      2'b11: begin
        pen.p1 = cfg.p1;
        pen.p2 = cfg.p2;
      end
      2'b00: begin
        pen.p1 = cfg.p1_tenth;
        pen.p2 = cfg.p2_tenth;
      end
      default: begin
        pen.p1 = cfg.p1 >> QUARTER_SHIFT;
        pen.p2 = cfg.p2 >> QUARTER_SHIFT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_grad <= '0;
    end else if (en) begin
      held_grad <= grad_right;
    end
  end

endmodule

[rtl/sgmpa_cost.sv]
// Cost datapath: best neighbor candidate, penalty-limited excess, saturating sum,
// running and previous pixel minimum, store write-back and result register.
// Depends on sgmpa_pkg.
module sgmpa_cost import sgmpa_pkg::*; #(
  parameter int AW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  cost_in_t          stage_in,
  input  logic [AW-1:0]     stage_addr,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [COST_W-1:0] wr_data,
  output logic              result_valid,
  output logic [COST_W-1:0] aggregated_cost,
  output logic              last_disparity,
  output logic [COST_W-1:0] pixel_minimum
);

  localparam logic [COST_W:0] CAND_NONE = '1;

  // candidate stage
  logic [COST_W-1:0] held_lower;
  logic [COST_W:0]   cand_lower;
  logic [COST_W:0]   cand_upper;
  logic [COST_W:0]   best;

  // result stage registers
  item_ctl_t         s3_ctl;
  logic [COST_W-1:0] s3_mc;
  logic [PEN_W-1:0]  s3_p2;
  logic [COST_W:0]   s3_best;
  logic [AW-1:0]     s3_addr;

  logic [COST_W-1:0] prev_min;
  logic [COST_W-1:0] run_min;

  logic              above_min;
  logic [COST_W:0]   excess;
  logic [COST_W:0]   step;
  logic [COST_W:0]   sum;
  logic [COST_W-1:0] result;
  logic [COST_W-1:0] run_min_base;
  logic [COST_W-1:0] run_min_next;

  always_comb begin
    cand_lower = stage_in.ctl.d_zero ? CAND_NONE
               : ({1'b0, held_lower} + {1'b0, stage_in.p1});
    cand_upper = stage_in.ctl.last ? CAND_NONE
               : ({1'b0, stage_in.next_cost} + {1'b0, stage_in.p1});
    best = {1'b0, stage_in.old_cost};
    if (cand_lower < best) best = cand_lower;
    if (cand_upper < best) best = cand_upper;
  end

  // min(best, prev_min + p2) - prev_min, floored at zero, as min(best - prev_min, p2)
  always_comb begin
    above_min = s3_best > {1'b0, prev_min};
    excess    = s3_best - {1'b0, prev_min};
    if (!above_min) begin
      step = '0;
    end else if (excess < {1'b0, s3_p2}) begin
      step = excess;
    end else begin
      step = {1'b0, s3_p2};
    end
    sum = {1'b0, s3_mc} + step;
    if (s3_ctl.first) begin
      result = s3_mc;
    end else if (sum[COST_W]) begin
      result = COST_MAX;
    end else begin
      result = sum[COST_W-1:0];
    end
    run_min_base = s3_ctl.d_zero ? COST_MAX : run_min;
    run_min_next = (result < run_min_base) ? result : run_min_base;
  end

  assign wr_en   = adv & s3_ctl.valid;
  assign wr_addr = s3_addr;
  assign wr_data = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl       <= '0;
      held_lower   <= COST_MAX;
      prev_min     <= COST_MAX;
      run_min      <= COST_MAX;
      result_valid <= 1'b0;
    end else if (adv) begin
      s3_ctl       <= stage_in.ctl;
      result_valid <= s3_ctl.valid;
      if (stage_in.ctl.valid && !stage_in.ctl.first) begin
        held_lower <= stage_in.old_cost;
      end
      if (s3_ctl.valid) begin
        run_min <= run_min_next;
        if (s3_ctl.last) begin
          prev_min <= run_min_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_mc   <= stage_in.match_cost;
      s3_p2   <= stage_in.p2;
      s3_best <= best;
      s3_addr <= stage_addr;
      if (s3_ctl.valid) begin
        aggregated_cost <= result;
        last_disparity  <= s3_ctl.last;
        pixel_minimum   <= s3_ctl.last ? run_min_next : '0;
      end
    end
  end

endmodule

[rtl/sgm_path_cost_aggregation_top.sv]
// Top level of the SGM path cost aggregation block: configuration registers,
// disparity counter, previous-pixel cost store, forwarding and interlock.
// Depends on sgmpa_pkg, sgmpa_penalty and sgmpa_cost.
//
// Usage
//   Item channel (item_valid / item_stall): one disparity element per transfer,
//   disparities 0 .. count-1 of a pixel in order, pixel after pixel along a path.
//   Result channel (result_valid / result_stall): one result per item, in order;
//   pixel_minimum carries the pixel minimum on the last disparity, else zero.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//   only while no item is in flight.
//   Pipeline: an item passes stage 1, stage 2, stage 3 and the result register.
//   Throughput: one item per cycle while item_stall is low. The cost store has
//   one write port, fed by the result stage; with a disparity count of three or
//   less the read of an entry still being written waits, so such items are
//   held off by item_stall.
//   Stall: when the result register is full and stalled, the whole pipeline
//   holds and item_stall rises in the same cycle.
//   Reset: configuration returns to its defaults and control state clears;
//   the cost store is not cleared, so the first pixel after reset must be
//   a path start.
module sgm_path_cost_aggregation_top import sgmpa_pkg::*; #(
  parameter int MAX_DISPARITIES = DEFAULT_MAX_DISPARITIES
) (
  input  logic                  clk,
  input  logic                  rst,
  // item channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [COST_W-1:0]     match_cost,
  input  logic                  path_start,
  input  logic [COLOR_W-1:0]    left_red,
  input  logic [COLOR_W-1:0]    left_green,
  input  logic [COLOR_W-1:0]    left_blue,
  input  logic [COLOR_W-1:0]    right_red,
  input  logic [COLOR_W-1:0]    right_green,
  input  logic [COLOR_W-1:0]    right_blue,
  input  logic [COLOR_W-1:0]    right_prev_red,
  input  logic [COLOR_W-1:0]    right_prev_green,
  input  logic [COLOR_W-1:0]    right_prev_blue,
  input  logic                  right_valid,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [COST_W-1:0]     aggregated_cost,
  output logic                  last_disparity,
  output logic [COST_W-1:0]     pixel_minimum,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_DISPARITIES);
  localparam int KW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers; tenth penalties are computed once per write.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] cfg_count;
  pen_cfg_t           pen_cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_count          <= COUNT_RESET;
      pen_cfg.threshold  <= THR_RESET;
      pen_cfg.p1         <= P1_RESET;
      pen_cfg.p2         <= P2_RESET;
      pen_cfg.p1_tenth   <= div_ten(P1_RESET);
      pen_cfg.p2_tenth   <= div_ten(P2_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DISPARITY_COUNT: cfg_count <= cfg_data[COUNT_W-1:0];
        REG_SMALL_PENALTY: begin
          pen_cfg.p1       <= cfg_data[PEN_W-1:0];
          pen_cfg.p1_tenth <= div_ten(cfg_data[PEN_W-1:0]);
        end
        REG_LARGE_PENALTY: begin
          pen_cfg.p2       <= cfg_data[PEN_W-1:0];
          pen_cfg.p2_tenth <= div_ten(cfg_data[PEN_W-1:0]);
        end
        REG_COLOR_THRESHOLD: pen_cfg.threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Disparity counter. A count of zero acts as one; counts above the store
  // depth act as the depth. The index wraps to zero after the last disparity.
  // ---------------------------------------------------------------------------
  logic [AW-1:0] disp_idx;
  logic [KW-1:0] count_raw;
  logic [KW-1:0] count_eff;
  logic          idx_last;
  logic          idx_zero;
  logic [AW-1:0] rd_addr0;
  logic [AW-1:0] rd_addr1;

  always_comb begin
    count_raw = KW'(cfg_count);
    if (count_raw == '0) begin
      count_eff = KW'(1);
    end else if (count_raw > KW'(MAX_DISPARITIES)) begin
      count_eff = KW'(MAX_DISPARITIES);
    end else begin
      count_eff = count_raw;
    end
    idx_last = (KW'(disp_idx) + KW'(1)) >= count_eff;
    idx_zero = (disp_idx == '0);
    rd_addr0 = disp_idx;
    rd_addr1 = disp_idx + AW'(1);   // upper neighbor, unused on the last disparity
  end

  // ---------------------------------------------------------------------------
  // Handshake. The pipeline advances when the result register is free or
  // being taken. An item is held off while an older item in stage 1 or stage 2,
  // not yet written back, targets one of the entries the new item reads.
  // ---------------------------------------------------------------------------
  logic          adv;
  logic          hazard;
  logic          accept;

  item_ctl_t     s1_ctl;
  logic [AW-1:0] s1_addr;
  item_ctl_t     s2_ctl;
  logic [AW-1:0] s2_addr;

  always_comb begin
    hazard = (s1_ctl.valid && ((s1_addr == rd_addr0) || (!idx_last && (s1_addr == rd_addr1))))
          || (s2_ctl.valid && ((s2_addr == rd_addr0) || (!idx_last && (s2_addr == rd_addr1))));
  end

  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv || hazard;
  assign accept     = item_valid && !item_stall;

  // ---------------------------------------------------------------------------
  // Per-pixel sampling: path_start and the left colour come from disparity zero.
  // ---------------------------------------------------------------------------
  logic first_flag;
  rgb_t cur_left;
  rgb_t prev_left;
  rgb_t in_left;

  assign in_left = '{red: left_red, green: left_green, blue: left_blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_idx   <= '0;
      first_flag <= 1'b1;
      cur_left   <= '0;
      prev_left  <= '0;
    end else if (accept) begin
      disp_idx <= idx_last ? '0 : (disp_idx + AW'(1));
      if (idx_zero) begin
        first_flag <= path_start;
        cur_left   <= in_left;
        prev_left  <= cur_left;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Cost store: previous pixel's aggregated costs, two read ports registered,
  // one write port fed by the result stage.
  // ---------------------------------------------------------------------------
  logic [COST_W-1:0] cost_mem [MAX_DISPARITIES];
  logic [COST_W-1:0] rd_data0;
  logic [COST_W-1:0] rd_data1;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [COST_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cost_mem[wr_addr] <= wr_data;
    end
    if (adv) begin
      rd_data0 <= cost_mem[rd_addr0];
      rd_data1 <= cost_mem[rd_addr1];
    end
  end

  // write that landed on the same edge as the read; the read returned old data
  logic              wq_en;
  logic [AW-1:0]     wq_addr;
  logic [COST_W-1:0] wq_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      wq_en <= 1'b0;
    end else if (adv) begin
      wq_en <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wq_addr <= wr_addr;
      wq_data <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: registered item, store read data arrives.
  // ---------------------------------------------------------------------------
  logic [COST_W-1:0] s1_mc;
  grad_in_t          s1_grad;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl.valid  <= accept;
      s1_ctl.first  <= idx_zero ? path_start : first_flag;
      s1_ctl.last   <= idx_last;
      s1_ctl.d_zero <= idx_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr                <= rd_addr0;
      s1_mc                  <= match_cost;
      s1_grad.d_zero         <= idx_zero;
      s1_grad.cur_left       <= idx_zero ? in_left : cur_left;
      s1_grad.prev_left      <= idx_zero ? cur_left : prev_left;
      s1_grad.right          <= '{red: right_red, green: right_green, blue: right_blue};
      s1_grad.right_prev     <= '{red: right_prev_red, green: right_prev_green,
                                  blue: right_prev_blue};
      s1_grad.right_valid    <= right_valid;
    end
  end

  // forwarding of the write that coincided with the read
  logic [AW-1:0]     s1_addr1;
  logic [COST_W-1:0] s1_old;
  logic [COST_W-1:0] s1_next;
  penalty_t          s1_pen;

  always_comb begin
    s1_addr1 = s1_addr + AW'(1);
    s1_old   = (wq_en && (wq_addr == s1_addr))  ? wq_data : rd_data0;
    s1_next  = (wq_en && (wq_addr == s1_addr1)) ? wq_data : rd_data1;
  end

  sgmpa_penalty u_penalty (
    .clk (clk),
    .rst (rst),
    .en  (adv && s1_ctl.valid),
    .gin (s1_grad),
    .cfg (pen_cfg),
    .pen (s1_pen)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: penalties and neighbor costs registered for the cost datapath.
  // ---------------------------------------------------------------------------
  logic [COST_W-1:0] s2_mc;
  penalty_t          s2_pen;
  logic [COST_W-1:0] s2_old;
  logic [COST_W-1:0] s2_next;
  cost_in_t          s2_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (adv) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_addr <= s1_addr;
      s2_mc   <= s1_mc;
      s2_pen  <= s1_pen;
      s2_old  <= s1_old;
      s2_next <= s1_next;
    end
  end

  always_comb begin
    s2_item.ctl        = s2_ctl;
    s2_item.match_cost = s2_mc;
    s2_item.p1         = s2_pen.p1;
    s2_item.p2         = s2_pen.p2;
    s2_item.old_cost   = s2_old;
    s2_item.next_cost  = s2_next;
  end

  // ---------------------------------------------------------------------------
  // Stages 3 and output: cost datapath, minima, write-back, result register.
  // ---------------------------------------------------------------------------
  sgmpa_cost #(
    .AW (AW)
  ) u_cost (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .stage_in        (s2_item),
    .stage_addr      (s2_addr),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .result_valid    (result_valid),
    .aggregated_cost (aggregated_cost),
    .last_disparity  (last_disparity),
    .pixel_minimum   (pixel_minimum)
  );

endmodule
